/* sv/efb_pkg.sv */
// shared types, constants and crc function for the ethernet frame builder
`default_nettype none

package efb_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] out_kind;
        logic       end_of_frame;
        logic [1:0] status;
    } out_beat_t;

    localparam logic [2:0] KIND_PREAMBLE = 3'd0;
    localparam logic [2:0] KIND_HEADER   = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [2:0] KIND_FCS      = 3'd3;
    localparam logic [2:0] KIND_GAP      = 3'd4;
    localparam logic [2:0] KIND_STATUS   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_MAC  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_MAC   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ETHER_TYPE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GAP   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FRAME = 3'd4;

    localparam logic [15:0] ETHER_TYPE_RESET = 16'h0800;
    localparam logic [5:0]  MIN_GAP_RESET    = 6'd12;
    localparam logic [10:0] MAX_FRAME_RESET  = 11'd1526;

    localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
    localparam logic [7:0]  SFD_BYTE       = 8'hD5;
    localparam logic [7:0]  GAP_BYTE       = 8'h07;
    localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;
    localparam logic [31:0] CRC_ONES       = 32'hFFFFFFFF;
    localparam logic [10:0] OVERHEAD_BYTES = 11'd26;
    localparam logic [5:0]  GAP_CAP        = 6'd32;
    localparam logic [5:0]  PRE_LAST_IDX   = 6'd7;
    localparam logic [5:0]  HDR_LAST_IDX   = 6'd13;
    localparam logic [5:0]  FCS_LAST_IDX   = 6'd3;

    // msb-first crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++)
        begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/ethernet_frame_builder_crc.sv */
// ethernet frame builder: preamble, header, payload, crc-32 fcs and gap fill or a status beat
//
//  channel  direction  handshake           beat
//  byte     in         byte_valid/stall    in_beat_t  (data_byte, last_byte)
//  frame    out        frame_valid/stall   out_beat_t (out_byte, kind, eof, status)
//  cfg      in         cfg_valid/ready     cfg_index, cfg_data
//
//  one frame beat per cycle from a held byte beat while frame_stall is low;
//  a byte beat gives 1 payload beat mid frame, 8 preamble + 14 header + 1
//  when it opens a frame, plus 1 status beat or 4 fcs + 1..36 gap beats
//  when it is the last; a dropped byte past the limit gives no payload beat
//  the next byte beat is taken in the cycle the held one finishes
//  reset clears the frame state and loads the register defaults
//  frame_stall holds the output register; the sequencer waits on it
`default_nettype none

module ethernet_frame_builder_crc
    import efb_pkg::*;
#(
    parameter int MIN_PAYLOAD = 46,
    parameter int COUNT_BITS  = 11
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      byte_valid,
    output      logic                      byte_stall,
    input  wire in_beat_t                  byte_beat,
    output      logic                      frame_valid,
    input  wire logic                      frame_stall,
    output      out_beat_t                 frame_beat,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int LIM_W = (COUNT_BITS > 11) ? COUNT_BITS : 11;

    typedef enum logic [2:0] {
        PH_PRE,
        PH_HDR,
        PH_PAY,
        PH_FCS,
        PH_GAP
    } phase_t;

    logic [47:0] dest_mac_reg;
    logic [47:0] src_mac_reg;
    logic [15:0] ether_type_reg;
    logic [5:0]  min_gap_reg;
    logic [10:0] max_frame_reg;

    logic                  item_valid_reg, item_valid_next;
    in_beat_t              item_reg, item_next;
    phase_t                phase_reg, phase_next;
    logic [5:0]            idx_reg, idx_next;
    logic                  in_frame_reg, in_frame_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [31:0]           crc_reg, crc_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_reg, out_next;

    logic        adv;
    logic        emit;
    logic        done;
    logic        go;
    logic        end_frame;
    logic        accept;
    out_beat_t   beat;
    logic [111:0] hdr_shift;
    logic [31:0]  fcs_shift;
    logic [10:0]  lim_raw;
    logic [LIM_W-1:0] cmax;
    logic [LIM_W-1:0] limit;
    logic         count_ok;
    logic         bad_frame;
    logic [5:0]   gap_cap;
    logic [1:0]   gap_rem;
    logic [5:0]   gap_len;

    assign cfg_ready   = 1'b1;
    assign frame_valid = out_valid_reg;
    assign frame_beat  = out_reg;

    assign adv = !out_valid_reg || !frame_stall;

    assign hdr_shift = {dest_mac_reg, src_mac_reg, ether_type_reg} << {idx_reg[3:0], 3'b000};
    assign fcs_shift = (crc_reg ^ CRC_ONES) << {idx_reg[1:0], 3'b000};

    assign lim_raw  = (max_frame_reg > OVERHEAD_BYTES) ? (max_frame_reg - OVERHEAD_BYTES) : 11'd0;
    assign cmax     = LIM_W'({COUNT_BITS{1'b1}});
    assign limit    = (LIM_W'(lim_raw) > cmax) ? cmax : LIM_W'(lim_raw);
    assign count_ok = LIM_W'(count_reg) < limit;

    assign bad_frame = ovf_reg || (count_reg < COUNT_BITS'(MIN_PAYLOAD));

    assign gap_cap = (min_gap_reg > GAP_CAP) ? GAP_CAP : min_gap_reg;
    assign gap_rem = 2'(OVERHEAD_BYTES[1:0] + count_reg[1:0] + gap_cap[1:0]);
    assign gap_len = gap_cap + 6'd4 - {4'b0000, gap_rem};

    always_comb
    begin
        emit       = 1'b0;
        done       = 1'b0;
        end_frame  = 1'b0;
        beat       = '0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        ovf_next   = ovf_reg;
        case (phase_reg)
            PH_PRE:
            begin
                emit          = 1'b1;
                beat.out_kind = KIND_PREAMBLE;
                beat.out_byte = (idx_reg == PRE_LAST_IDX) ? SFD_BYTE : PREAMBLE_BYTE;
                if (idx_reg == PRE_LAST_IDX)
                begin
                    phase_next = PH_HDR;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            PH_HDR:
            begin
                emit          = 1'b1;
                beat.out_kind = KIND_HEADER;
                beat.out_byte = hdr_shift[111:104];
                crc_next      = crc_byte(crc_reg, hdr_shift[111:104]);
                if (idx_reg == HDR_LAST_IDX)
                begin
                    phase_next = PH_PAY;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            PH_PAY:
            begin
                if (count_ok)
                begin
                    emit          = 1'b1;
                    beat.out_kind = KIND_PAYLOAD;
                    beat.out_byte = item_reg.data_byte;
                    crc_next      = crc_byte(crc_reg, item_reg.data_byte);
                    count_next    = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (item_reg.last_byte)
                begin
                    phase_next = PH_FCS;
                    idx_next   = '0;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_FCS:
            begin
                emit = 1'b1;
                if (idx_reg == '0 && bad_frame)
                begin
                    beat.out_kind     = KIND_STATUS;
                    beat.end_of_frame = 1'b1;
                    beat.status       = ovf_reg ? ST_TOO_LONG : ST_TOO_SHORT;
                    done              = 1'b1;
                    end_frame         = 1'b1;
                    count_next        = '0;
                    crc_next          = CRC_ONES;
                    ovf_next          = 1'b0;
                end
                else
                begin
                    beat.out_kind = KIND_FCS;
                    beat.out_byte = fcs_shift[31:24];
                    if (idx_reg == FCS_LAST_IDX)
                    begin
                        phase_next = PH_GAP;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            PH_GAP:
            begin
                emit          = 1'b1;
                beat.out_kind = KIND_GAP;
                beat.out_byte = GAP_BYTE;
                if (idx_reg == gap_len - 6'd1)
                begin
                    beat.end_of_frame = 1'b1;
                    done              = 1'b1;
                    end_frame         = 1'b1;
                    count_next        = '0;
                    crc_next          = CRC_ONES;
                    ovf_next          = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign go         = item_valid_reg && (adv || !emit);
    assign byte_stall = item_valid_reg && !(go && done);
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        in_frame_next   = in_frame_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (adv)
        begin
            out_valid_next = go && emit;
            out_next       = beat;
        end
        if (go)
        begin
            if (end_frame)
            begin
                in_frame_next = 1'b0;
            end
            if (done)
            begin
                item_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            item_valid_next = 1'b1;
            item_next       = byte_beat;
            in_frame_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_mac_reg   <= '0;
            src_mac_reg    <= '0;
            ether_type_reg <= ETHER_TYPE_RESET;
            min_gap_reg    <= MIN_GAP_RESET;
            max_frame_reg  <= MAX_FRAME_RESET;
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_PRE;
            idx_reg        <= '0;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            crc_reg        <= CRC_ONES;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEST_MAC:   dest_mac_reg   <= cfg_data;
                    REG_SRC_MAC:    src_mac_reg    <= cfg_data;
                    REG_ETHER_TYPE: ether_type_reg <= cfg_data[15:0];
                    REG_MIN_GAP:    min_gap_reg    <= cfg_data[5:0];
                    REG_MAX_FRAME:  max_frame_reg  <= cfg_data[10:0];
                    default:        ;
                endcase
            end
            item_valid_reg <= item_valid_next;
            in_frame_reg   <= in_frame_next;
            out_valid_reg  <= out_valid_next;
            if (go)
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                ovf_reg   <= ovf_next;
            end
            if (accept)
            begin
                phase_reg <= (in_frame_reg && !(go && end_frame)) ? PH_PAY : PH_PRE;
                idx_reg   <= '0;
            end
            else if (go)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    // a nonzero status only rides on the closing status beat
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_beat.status != ST_OK
            |-> frame_beat.out_kind == KIND_STATUS && frame_beat.end_of_frame)
        else $error("status on a non-status beat");

    // a held byte beat always belongs to an open frame
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> in_frame_reg)
        else $error("byte beat held outside a frame");

    // between frames the crc, count and overflow sit at their start values
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> count_reg == '0 && !ovf_reg && crc_reg == CRC_ONES)
        else $error("frame state not cleared between frames");

    // the gap never runs past its computed length
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && phase_reg == PH_GAP |-> idx_reg < gap_len)
        else $error("gap index out of range");

    // a frame that opens starts with the preamble
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_frame_reg |=> phase_reg == PH_PRE && idx_reg == '0)
        else $error("frame did not open with preamble");

endmodule

`default_nettype wire

/* verif/ethernet_frame_builder_crc_tb.sv */
// self-checking testbench for the ethernet frame builder with crc-32 fcs
`default_nettype none

module ethernet_frame_builder_crc_tb;
    import efb_pkg::*;

    localparam int PAYLOAD_FLOOR  = 46;
    localparam int COUNT_WIDTH    = 11;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_LIMIT   = 10;

    class frame_checker;
        out_beat_t   expected_beats[$];
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [5:0]  min_gap;
        logic [10:0] max_frame;
        bit          in_frame;
        bit          overflow;
        int unsigned payload_count;
        logic [31:0] crc;
        int          errors;
        int          beats_seen;
        int          bytes_seen;
        int          frames_ok;
        int          frames_short;
        int          frames_long;

        function new();
            dest_mac      = '0;
            src_mac       = '0;
            ether_type    = ETHER_TYPE_RESET;
            min_gap       = MIN_GAP_RESET;
            max_frame     = MAX_FRAME_RESET;
            in_frame      = 1'b0;
            overflow      = 1'b0;
            payload_count = 0;
            crc           = CRC_ONES;
            errors        = 0;
            beats_seen    = 0;
            bytes_seen    = 0;
            frames_ok     = 0;
            frames_short  = 0;
            frames_long   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
            case (index)
                REG_DEST_MAC:   dest_mac   = data[47:0];
                REG_SRC_MAC:    src_mac    = data[47:0];
                REG_ETHER_TYPE: ether_type = data[15:0];
                REG_MIN_GAP:    min_gap    = data[5:0];
                REG_MAX_FRAME:  max_frame  = data[10:0];
                default: ;
            endcase
        endfunction

        function int unsigned payload_limit();
            int unsigned lim;
            lim = (max_frame > OVERHEAD_BYTES) ? max_frame - OVERHEAD_BYTES : 0;
            if (lim > (1 << COUNT_WIDTH) - 1)
                lim = (1 << COUNT_WIDTH) - 1;
            return lim;
        endfunction

        function void push(logic [7:0] b, logic [2:0] kind, logic eof, logic [1:0] st);
            out_beat_t e;
            e.out_byte     = b;
            e.out_kind     = kind;
            e.end_of_frame = eof;
            e.status       = st;
            expected_beats.push_back(e);
        endfunction

        function void fold(logic [7:0] b);
            crc ^= {b, 24'h000000};
            repeat (8)
                crc = (crc << 1) ^ (crc[31] ? CRC_POLY : 32'h0);
        endfunction

        function void header_byte(logic [7:0] b);
            fold(b);
            push(b, KIND_HEADER, 1'b0, ST_OK);
        endfunction

        function void note_byte(in_beat_t b);
            int unsigned gap_base;
            int unsigned total;
            int unsigned gap_len;
            logic [31:0] fcs;
            bytes_seen++;
            if (!in_frame)
            begin
                repeat (7)
                    push(PREAMBLE_BYTE, KIND_PREAMBLE, 1'b0, ST_OK);
                push(SFD_BYTE, KIND_PREAMBLE, 1'b0, ST_OK);
                crc           = CRC_ONES;
                payload_count = 0;
                overflow      = 1'b0;
                for (int i = 0; i < 6; i++)
                    header_byte(dest_mac[47-8*i -: 8]);
                for (int i = 0; i < 6; i++)
                    header_byte(src_mac[47-8*i -: 8]);
                header_byte(ether_type[15:8]);
                header_byte(ether_type[7:0]);
                in_frame = 1'b1;
            end
            if (payload_count < payload_limit())
            begin
                fold(b.data_byte);
                push(b.data_byte, KIND_PAYLOAD, 1'b0, ST_OK);
                payload_count++;
            end
            else
                overflow = 1'b1;
            if (b.last_byte)
            begin
                if (overflow)
                begin
                    push(8'h00, KIND_STATUS, 1'b1, ST_TOO_LONG);
                    frames_long++;
                end
                else if (payload_count < PAYLOAD_FLOOR)
                begin
                    push(8'h00, KIND_STATUS, 1'b1, ST_TOO_SHORT);
                    frames_short++;
                end
                else
                begin
                    fcs = ~crc;
                    for (int i = 0; i < 4; i++)
                        push(fcs[31-8*i -: 8], KIND_FCS, 1'b0, ST_OK);
                    gap_base = (min_gap > GAP_CAP) ? GAP_CAP : min_gap;
                    total    = OVERHEAD_BYTES + payload_count + gap_base;
                    gap_len  = gap_base + 4 - total % 4;
                    for (int j = 0; j < gap_len; j++)
                        push(GAP_BYTE, KIND_GAP, j == gap_len - 1, ST_OK);
                    frames_ok++;
                end
                in_frame      = 1'b0;
                payload_count = 0;
                crc           = CRC_ONES;
                overflow      = 1'b0;
            end
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t exp;
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected frame beat %0d: byte %02h kind %0d eof %0b status %0d",
                             beats_seen, got.out_byte, got.out_kind, got.end_of_frame,
                             got.status);
                return;
            end
            exp = expected_beats.pop_front();
            if (got.out_byte !== exp.out_byte || got.out_kind !== exp.out_kind ||
                got.end_of_frame !== exp.end_of_frame || got.status !== exp.status)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("frame beat %0d: expected %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                             beats_seen, exp.out_byte, exp.out_kind, exp.end_of_frame,
                             exp.status, got.out_byte, got.out_kind, got.end_of_frame,
                             got.status);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      byte_valid  = 1'b0;
    logic                      byte_stall;
    in_beat_t                  byte_beat   = '0;
    logic                      frame_valid;
    logic                      frame_stall = 1'b0;
    out_beat_t                 frame_beat;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;

    bit           steady    = 1'b0;
    bit           hold_req  = 1'b0;
    int           hold_left = 0;
    int           quiet     = 0;
    int           phases    = 0;
    frame_checker frames;

    ethernet_frame_builder_crc u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_beat   (byte_beat),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_beat  (frame_beat),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // frame side: random stall, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && frame_valid && !frame_stall)
                frames.check_beat(frame_beat);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                frame_stall <= 1'b1;
                hold_left--;
            end
            else
                frame_stall <= !steady && ($urandom_range(99) < 33);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && !byte_stall) || (frame_valid && !frame_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("ethernet_frame_builder_crc_tb failed");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic int pick_length();
        int unsigned lim;
        int          roll;
        lim  = frames.payload_limit();
        roll = $urandom_range(99);
        if (roll < 15)
            return $urandom_range(4, 1);
        if (roll < 30)
            return $urandom_range(45, 5);
        if (lim >= PAYLOAD_FLOOR && (roll < 80 || lim >= 62))
            return $urandom_range((lim < 60) ? lim : 60, PAYLOAD_FLOOR);
        return $urandom_range(lim + 3, lim + 1);
    endfunction

    task automatic send_byte(logic [7:0] data, logic last);
        in_beat_t b;
        b.data_byte = data;
        b.last_byte = last;
        while (!steady && $urandom_range(99) < 33)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat  <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        frames.note_byte(b);
    endtask

    task automatic send_frame(int len);
        for (int n = 0; n < len; n++)
            send_byte(8'($urandom_range(255)), n == len - 1);
    endtask

    task automatic settle();
        while (frames.expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_registers(logic [47:0] dst, logic [47:0] src, logic [15:0] etype,
                                  logic [5:0] gap, logic [10:0] max_len);
        logic [CFG_INDEX_BITS-1:0] regs [5];
        logic [CFG_DATA_BITS-1:0]  vals [5];
        regs[0] = REG_DEST_MAC;
        regs[1] = REG_SRC_MAC;
        regs[2] = REG_ETHER_TYPE;
        regs[3] = REG_MIN_GAP;
        regs[4] = REG_MAX_FRAME;
        vals[0] = dst;
        vals[1] = src;
        vals[2] = 48'(etype);
        vals[3] = 48'(gap);
        vals[4] = 48'(max_len);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            frames.write_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [47:0] dst, logic [47:0] src, logic [15:0] etype,
                             logic [5:0] gap, logic [10:0] max_len, int budget, bit press);
        int sent;
        int len;
        sent = 0;
        settle();
        load_registers(dst, src, etype, gap, max_len);
        phases++;
        if (press)
            hold_req = 1'b1;
        while (sent < budget)
        begin
            len = pick_length();
            send_frame(len);
            sent += len;
        end
        byte_valid <= 1'b0;
    endtask

    initial
    begin
        frames = new();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short frames with extreme payload bytes at reset settings
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        byte_valid <= 1'b0;

        run_phase(48'hFFFF_FFFF_FFFF, 48'h0, 16'hFFFF, 6'd0, 11'd72, 15, 1'b0);
        run_phase(rand48(), 48'hFFFF_FFFF_FFFF, 16'h0000, 6'd32, 11'd2047, 20, 1'b1);
        steady = 1'b1;
        run_phase(rand48(), rand48(), 16'($urandom_range(65535)), 6'd63, 11'd73, 25, 1'b0);
        steady = 1'b0;
        run_phase(rand48(), rand48(), 16'($urandom_range(65535)), 6'($urandom_range(32)),
                  11'd25, 6, 1'b0);
        run_phase(rand48(), rand48(), 16'($urandom_range(65535)), 6'($urandom_range(32)),
                  11'($urandom_range(100, 72)), 15, 1'b0);
        settle();

        if (frames.expected_beats.size() != 0)
        begin
            frames.errors += frames.expected_beats.size();
            $display("%0d expected frame beats never arrived", frames.expected_beats.size());
        end
        $display("sent %0d bytes, %0d register sets: %0d good, %0d short, %0d long frames",
                 frames.bytes_seen, phases + 1, frames.frames_ok, frames.frames_short,
                 frames.frames_long);
        $display("checked %0d frame beats, %0d mismatches", frames.beats_seen, frames.errors);
        if (frames.errors == 0)
            $display("ethernet_frame_builder_crc_tb passed");
        else
            $display("ethernet_frame_builder_crc_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
